// ===== hw/rtl/lgh_pkg.sv =====
// Package for the lock-grant hash table: sizes, codes, entry layout.
// No dependencies.
package lgh_pkg;
  localparam int unsigned Slots = 1024;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = SlotW + 1;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam int unsigned KeyBytes = 29;
  localparam int unsigned KeyW = 8 * KeyBytes;
  // key 232 + owner 8 + mode 3 + epoch 64 + time 64
  localparam int unsigned EntryW = KeyW + 8 + 3 + 64 + 64;
  // entry plus valid bit on top
  localparam int unsigned RamW = EntryW + 1;

  typedef enum logic [1:0] {
    CMD_GRANT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_PURGE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK,
    S_PURGE,
    S_DONE
  } state_e;
endpackage

// ===== hw/rtl/lgh_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module lgh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/lock_grant_hash_table.sv =====
// Lock-grant hash table: open addressing, FNV-1a home slot, linear probing.
// From acceptance to result: grant/clear hash the key byte by byte, then read and
// check each probed slot, then done; purge reads and checks every slot, then done.
// One transaction at a time; ready returns once the result is registered.
// Reset clears the sequencer; a pass over every slot then clears the valid bits in
// the entry RAM before the input opens. Depends on lgh_pkg and lgh_ram.
module lock_grant_hash_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   cmd_i,
  input  logic [63:0]  res_volume_i,
  input  logic [63:0]  res_inode_i,
  input  logic [63:0]  res_offset_i,
  input  logic [31:0]  res_group_i,
  input  logic [7:0]   res_kind_i,
  input  logic [7:0]   owner_i,
  input  logic [2:0]   mode_i,
  input  logic [63:0]  epoch_i,
  input  logic [63:0]  time_ms_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [9:0]   slot_o,
  output logic [10:0]  purge_count_o
);
  localparam int unsigned SW = lgh_pkg::SlotW;
  localparam int unsigned CW = lgh_pkg::CntW;

  lgh_pkg::state_e state_q, state_d;

  // captured transaction
  logic [1:0]               cmd_q;
  logic [lgh_pkg::KeyW-1:0] key_q;
  logic [7:0]               owner_q;
  logic [2:0]               mode_q;
  logic [63:0]              epoch_q, time_q;

  logic [31:0] hash_q;
  logic [4:0]  byte_q;      // hash byte index
  logic [SW-1:0] slot_q;    // probe/scan/clear position
  logic [CW-1:0] steps_q;   // probe steps or purge count

  // working result
  logic [1:0]  status_q;
  logic [9:0]  res_slot_q;
  logic [10:0] res_cnt_q;

  // output register, held while the result waits
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [9:0]  out_slot_q;
  logic [10:0] out_cnt_q;

  // entry RAM, valid bit on top
  logic                       ram_we, wr_valid;
  logic [lgh_pkg::RamW-1:0]   ram_wdata, ram_rdata;
  logic [lgh_pkg::KeyW-1:0]   rd_key;
  logic [7:0]                 rd_owner;
  logic                       rd_valid;

  assign ram_wdata = {wr_valid, time_q, epoch_q, mode_q, owner_q, key_q};
  assign rd_key    = ram_rdata[lgh_pkg::KeyW-1:0];
  assign rd_owner  = ram_rdata[lgh_pkg::KeyW +: 8];
  assign rd_valid  = ram_rdata[lgh_pkg::EntryW];

  lgh_ram #(
    .Width(lgh_pkg::RamW),
    .Depth(lgh_pkg::Slots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (slot_q),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // one FNV-1a byte step; key bytes least significant first
  logic [31:0] hash_next;
  logic [7:0]  key_byte;
  always_comb begin
    key_byte  = key_q[{byte_q, 3'b000} +: 8];
    hash_next = (hash_q ^ {24'd0, key_byte}) * lgh_pkg::FnvPrime;
  end

  logic key_hit, owner_hit, steps_done, slot_last;
  assign owner_hit  = rd_valid && (rd_owner == owner_q);
  assign key_hit    = (rd_key == key_q) && owner_hit;
  assign steps_done = (steps_q == CW'(lgh_pkg::Slots - 1));
  assign slot_last  = (slot_q == SW'(lgh_pkg::Slots - 1));

  assign in_ready_o    = (state_q == lgh_pkg::S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign purge_count_o = out_cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgh_pkg::S_INIT: begin
        if (slot_last) state_d = lgh_pkg::S_IDLE;
      end
      lgh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (lgh_pkg::cmd_e'(cmd_i)) inside
            lgh_pkg::CMD_GRANT, lgh_pkg::CMD_CLEAR: state_d = lgh_pkg::S_HASH;
            lgh_pkg::CMD_PURGE:                     state_d = lgh_pkg::S_RD;
            default:                                state_d = lgh_pkg::S_DONE;
          endcase
        end
      end
      lgh_pkg::S_HASH: begin
        if (byte_q == 5'(lgh_pkg::KeyBytes - 1)) state_d = lgh_pkg::S_RD;
      end
      lgh_pkg::S_RD: begin
        if (cmd_q == lgh_pkg::CMD_PURGE) state_d = lgh_pkg::S_PURGE;
        else state_d = lgh_pkg::S_CHK;
      end
      lgh_pkg::S_CHK: begin
        if (!rd_valid || key_hit || steps_done) state_d = lgh_pkg::S_DONE;
        else state_d = lgh_pkg::S_RD;
      end
      lgh_pkg::S_PURGE: begin
        state_d = slot_last ? lgh_pkg::S_DONE : lgh_pkg::S_RD;
      end
      lgh_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = lgh_pkg::S_IDLE;
      end
      default: state_d = lgh_pkg::S_IDLE;
    endcase
  end

  // RAM write: clearing pass, grant on hit or at the empty slot, clear, purge
  always_comb begin
    ram_we   = 1'b0;
    wr_valid = 1'b0;
    unique case (state_q)
      lgh_pkg::S_INIT: ram_we = 1'b1;
      lgh_pkg::S_CHK: begin
        if (cmd_q == lgh_pkg::CMD_GRANT) begin
          ram_we   = !rd_valid || key_hit;
          wr_valid = 1'b1;
        end else begin
          ram_we = key_hit;
        end
      end
      lgh_pkg::S_PURGE: ram_we = owner_hit;
      default:          ram_we = 1'b0;
    endcase
  end

  // captured transaction, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      key_q   <= {res_kind_i, res_group_i, res_offset_i, res_inode_i, res_volume_i};
      owner_q <= owner_i;
      mode_q  <= mode_i;
      epoch_q <= epoch_i;
      time_q  <= time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lgh_pkg::S_INIT;
      out_valid_q  <= 1'b0;
      hash_q       <= '0;
      byte_q       <= '0;
      slot_q       <= '0;
      steps_q      <= '0;
      status_q     <= '0;
      res_slot_q   <= '0;
      res_cnt_q    <= '0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        lgh_pkg::S_INIT: begin
          slot_q <= slot_q + SW'(1);
        end
        lgh_pkg::S_IDLE: begin
          hash_q     <= lgh_pkg::FnvBasis;
          byte_q     <= '0;
          slot_q     <= '0;
          steps_q    <= '0;
          status_q   <= lgh_pkg::ST_OK;
          res_slot_q <= '0;
          res_cnt_q  <= '0;
        end
        lgh_pkg::S_HASH: begin
          hash_q <= hash_next;
          byte_q <= byte_q + 5'd1;
          // Slots is a power of two: home slot is the low hash bits
          if (byte_q == 5'(lgh_pkg::KeyBytes - 1)) slot_q <= hash_next[SW-1:0];
        end
        lgh_pkg::S_CHK: begin
          if (!rd_valid) begin
            if (cmd_q == lgh_pkg::CMD_GRANT) res_slot_q <= 10'(slot_q);
            else status_q <= lgh_pkg::ST_NOT_FOUND;
          end else if (key_hit) begin
            res_slot_q <= 10'(slot_q);
          end else if (steps_done) begin
            status_q <= (cmd_q == lgh_pkg::CMD_GRANT) ? lgh_pkg::ST_NO_SPACE
                                                      : lgh_pkg::ST_NOT_FOUND;
          end else begin
            slot_q  <= slot_q + SW'(1);
            steps_q <= steps_q + CW'(1);
          end
        end
        lgh_pkg::S_PURGE: begin
          if (owner_hit) begin
            steps_q   <= steps_q + CW'(1);
            res_cnt_q <= 11'(steps_q + CW'(1));
          end
          slot_q <= slot_q + SW'(1);
        end
        lgh_pkg::S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_slot_q   <= res_slot_q;
            out_cnt_q    <= res_cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  // a result only appears on leaving the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == lgh_pkg::S_DONE)
    else $error("result without completed transaction");

  // the input side is closed while a transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != lgh_pkg::S_IDLE |-> !in_ready_o)
    else $error("ready while busy");

  // a failed grant or clear reports no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != lgh_pkg::ST_OK |-> out_slot_q == '0)
    else $error("slot reported on failure");
endmodule
